// File: hdl/command_line_unescape_parser_assert.svh
// Assertion macros for the command line parser.
`ifndef COMMAND_LINE_UNESCAPE_PARSER_ASSERT_SVH
`define COMMAND_LINE_UNESCAPE_PARSER_ASSERT_SVH

`ifndef SYNTH
`define CLUP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clup assertion failed");
`define CLUP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clup assertion failed");
`else
`define CLUP_ASSERT_IMP(label, ante, cons)
`define CLUP_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: hdl/clup_pkg.sv
`timescale 1ns / 1ps

package clup_pkg;

    localparam logic [2:0] KIND_TYPE   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_PARAM  = 3'd2;
    localparam logic [2:0] KIND_PEND   = 3'd3;
    localparam logic [2:0] KIND_OK     = 3'd4;
    localparam logic [2:0] KIND_REJECT = 3'd5;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_SHORT       = 2'd1;
    localparam logic [1:0] ERR_ESC_EOL     = 2'd2;
    localparam logic [1:0] ERR_ESC_UNKNOWN = 2'd3;

    localparam int MIN_LEN_NORMAL_I = 5 + (8 * 8 + 7) / 5;
    localparam logic [4:0] MIN_LEN_NORMAL = 5'(MIN_LEN_NORMAL_I);
    localparam logic [4:0] MIN_LEN_LEGACY = 5'd7;
    localparam logic [4:0] POS_SAT        = 5'd19;
    localparam logic [4:0] PARAM_START_NORMAL = 5'd5;
    localparam logic [4:0] PARAM_START_LEGACY = 5'd8;
    localparam logic [4:0] LEGACY_CMD_FIRST   = 5'd4;
    localparam logic [4:0] LEGACY_CMD_LAST    = 5'd6;
    localparam logic [4:0] NORMAL_CMD_LAST    = 5'd3;

    localparam logic [7:0] CLIENT_TYPE = 8'h43;
    localparam logic [7:0] CHAR_S      = 8'h73;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] BACKSLASH   = 8'h5C;
    localparam logic [7:0] SPACE       = 8'h20;
    localparam logic [7:0] NEWLINE     = 8'h0A;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [1:0] error_code;
    } result_t;

    // count is 1..3, results packed from slot 0
    typedef struct packed {
        logic [1:0]      count;
        result_t [2:0]   res;
    } bundle_t;

endpackage

// File: hdl/clup_if.sv
`timescale 1ns / 1ps

interface clup_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       end_of_line;
    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink (input valid, input line_byte, input end_of_line, output ready);
endinterface

interface clup_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [1:0] error_code;
    logic       last_of_run;
    modport source (output valid, output kind, output value, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input value, input error_code,
                  input last_of_run, output ready);
endinterface

interface clup_cfg_if;
    logic valid;
    logic ready;
    logic legacy_mode;
    modport source (output valid, output legacy_mode, input ready);
    modport sink (input valid, input legacy_mode, output ready);
endinterface

// File: hdl/command_line_unescape_parser.sv
`timescale 1ns / 1ps
// Command line splitter and unescaper.
// line:   one raw byte per transfer, end_of_line set on the last byte of a line.
// result: type char, command chars, decoded parameter bytes, parameter ends, and
//         one verdict per line (ok, or rejected with error_code). last_of_run
//         marks the final result caused by one input byte. On a rejected line
//         the receiver drops everything already taken for that line.
// cfg:    write of legacy_mode, only while the block is idle; always ready.
// A byte is taken every cycle while the result queue has room. Each byte makes
// zero to three results; the output side sends one result per cycle while the receiver is ready.
// Each byte's results pass through the queue and then the output register
// before they are valid. The queue holds QUEUE_DEPTH bytes' worth of results.
// A stalled result receiver fills the queue, then line.ready drops; the
// current result holds on the port until taken.
// Reset clears line state, the queue and legacy_mode (normal format).
`include "command_line_unescape_parser_assert.svh"

module command_line_unescape_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    clup_line_if.sink     line,
    clup_result_if.source result,
    clup_cfg_if.sink      cfg
);
    import clup_pkg::*;

    logic    q_push, q_pop, q_full, q_empty;
    bundle_t q_in, q_out;

    clup_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    clup_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    clup_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .result  (result)
    );

    `CLUP_ASSERT_IMP(a_verdict_last, result.valid && (result.kind == KIND_OK || result.kind == KIND_REJECT), result.last_of_run)
    `CLUP_ASSERT_IMP(a_err_only_reject, result.valid && result.kind != KIND_REJECT, result.error_code == ERR_NONE)
    `CLUP_ASSERT_NXT(a_run_continues, result.valid && result.ready && !result.last_of_run, result.valid)
    `CLUP_ASSERT_IMP(a_push_room, q_push, !q_full)

endmodule

// File: hdl/clup_front.sv
`timescale 1ns / 1ps

module clup_front (
    input  logic              clk,
    input  logic              rst_n,
    clup_line_if.sink         line,
    clup_cfg_if.sink          cfg,
    input  logic              q_full,
    output logic              q_push,
    output clup_pkg::bundle_t q_data
);
    import clup_pkg::*;

    logic       legacy_mode_reg;
    logic [4:0] byte_position_reg, byte_position_next;
    logic       escape_pending_reg, escape_pending_next;
    logic       param_nonempty_reg, param_nonempty_next;
    logic [1:0] pending_error_reg, pending_error_next;

    logic       accept;
    logic [4:0] p;
    logic [7:0] b;
    logic       eol;
    logic [4:0] param_start;
    logic [4:0] min_len;
    logic [4:0] count;
    logic       has_a;
    result_t    a;
    bundle_t    bnd;
    logic [1:0] n;
    logic [7:0] dec;
    logic       dec_ok;

    assign line.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign accept     = line.valid && line.ready;

    assign p   = byte_position_reg;
    assign b   = line.line_byte;
    assign eol = line.end_of_line;
    assign param_start = legacy_mode_reg ? PARAM_START_LEGACY : PARAM_START_NORMAL;
    assign min_len     = legacy_mode_reg ? MIN_LEN_LEGACY : MIN_LEN_NORMAL;
    assign count       = (p >= POS_SAT) ? POS_SAT : p + 5'd1;

    always_comb
    begin
        dec_ok = 1'b1;
        dec    = 8'd0;
        if (b == CHAR_S)
        begin
            dec = SPACE;
        end
        else if (b == CHAR_N)
        begin
            dec = NEWLINE;
        end
        else if (b == BACKSLASH)
        begin
            dec = BACKSLASH;
        end
        else if (b == SPACE && legacy_mode_reg)
        begin
            dec = SPACE;
        end
        else
        begin
            dec_ok = 1'b0;
        end
    end

    always_comb
    begin
        has_a               = 1'b0;
        a                   = '0;
        escape_pending_next = escape_pending_reg;
        param_nonempty_next = param_nonempty_reg;
        pending_error_next  = pending_error_reg;
        byte_position_next  = count;
        bnd                 = '0;
        n                   = 2'd0;

        if (p < param_start)
        begin
            if (legacy_mode_reg)
            begin
                if (p == 5'd0)
                begin
                    has_a = 1'b1;
                    a     = '{kind: KIND_TYPE, value: CLIENT_TYPE, error_code: ERR_NONE};
                end
                else if (p inside {[LEGACY_CMD_FIRST:LEGACY_CMD_LAST]})
                begin
                    has_a = 1'b1;
                    a     = '{kind: KIND_CMD, value: b, error_code: ERR_NONE};
                end
            end
            else
            begin
                if (p == 5'd0)
                begin
                    has_a = 1'b1;
                    a     = '{kind: KIND_TYPE, value: b, error_code: ERR_NONE};
                end
                else if (p <= NORMAL_CMD_LAST)
                begin
                    has_a = 1'b1;
                    a     = '{kind: KIND_CMD, value: b, error_code: ERR_NONE};
                end
            end
        end
        else if (pending_error_reg == ERR_NONE)
        begin
            if (escape_pending_reg)
            begin
                escape_pending_next = 1'b0;
                if (dec_ok)
                begin
                    has_a               = 1'b1;
                    a                   = '{kind: KIND_PARAM, value: dec, error_code: ERR_NONE};
                    param_nonempty_next = 1'b1;
                end
                else
                begin
                    pending_error_next = ERR_ESC_UNKNOWN;
                end
            end
            else if (b == BACKSLASH)
            begin
                if (eol)
                begin
                    pending_error_next = ERR_ESC_EOL;
                end
                else
                begin
                    escape_pending_next = 1'b1;
                end
            end
            else if (b == SPACE)
            begin
                has_a               = 1'b1;
                a                   = '{kind: KIND_PEND, value: 8'd0, error_code: ERR_NONE};
                param_nonempty_next = 1'b0;
            end
            else
            begin
                has_a               = 1'b1;
                a                   = '{kind: KIND_PARAM, value: b, error_code: ERR_NONE};
                param_nonempty_next = 1'b1;
            end
        end

        if (has_a)
        begin
            bnd.res[0] = a;
            n          = 2'd1;
        end

        if (eol)
        begin
            if (count < min_len)
            begin
                bnd.res[n] = '{kind: KIND_REJECT, value: 8'd0, error_code: ERR_SHORT};
                n          = n + 2'd1;
            end
            else if (pending_error_next != ERR_NONE)
            begin
                bnd.res[n] = '{kind: KIND_REJECT, value: 8'd0,
                               error_code: pending_error_next};
                n          = n + 2'd1;
            end
            else
            begin
                if (param_nonempty_next)
                begin
                    bnd.res[n] = '{kind: KIND_PEND, value: 8'd0, error_code: ERR_NONE};
                    n          = n + 2'd1;
                end
                bnd.res[n] = '{kind: KIND_OK, value: 8'd0, error_code: ERR_NONE};
                n          = n + 2'd1;
            end
            byte_position_next  = 5'd0;
            escape_pending_next = 1'b0;
            param_nonempty_next = 1'b0;
            pending_error_next  = ERR_NONE;
        end
        bnd.count = n;
    end

    assign q_push = accept && (n != 2'd0);
    assign q_data = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            legacy_mode_reg    <= 1'b0;
            byte_position_reg  <= 5'd0;
            escape_pending_reg <= 1'b0;
            param_nonempty_reg <= 1'b0;
            pending_error_reg  <= ERR_NONE;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                legacy_mode_reg <= cfg.legacy_mode;
            end
            if (accept)
            begin
                byte_position_reg  <= byte_position_next;
                escape_pending_reg <= escape_pending_next;
                param_nonempty_reg <= param_nonempty_next;
                pending_error_reg  <= pending_error_next;
            end
        end
    end

endmodule

// File: hdl/clup_queue.sv
`timescale 1ns / 1ps

module clup_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  clup_pkg::bundle_t push_data,
    output logic              full,
    input  logic              pop,
    output clup_pkg::bundle_t pop_data,
    output logic              empty
);
    import clup_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ((wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1)
                              : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1)
                             : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/clup_back.sv
`timescale 1ns / 1ps

module clup_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  clup_pkg::bundle_t q_data,
    output logic              q_pop,
    clup_result_if.source     result
);
    import clup_pkg::*;

    bundle_t    bund_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       xfer;
    logic       done;
    result_t    cur;

    assign last  = (idx_reg == bund_reg.count - 2'd1);
    assign xfer  = busy_reg && result.ready;
    assign done  = !busy_reg || (xfer && last);
    assign q_pop = done && !q_empty;
    assign cur   = bund_reg.res[idx_reg];

    assign result.valid       = busy_reg;
    assign result.kind        = cur.kind;
    assign result.value       = cur.value;
    assign result.error_code  = cur.error_code;
    assign result.last_of_run = last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (xfer)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bund_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule
